// ===== hdl/snc_pkg.sv =====
// Shared constants, types and helper functions for the substring occurrence counter.
`timescale 1ns / 1ps

package snc_pkg;

    // Longest pattern that the window can hold.
    localparam int PATTERN_MAX = 16;
    // Number of pattern bytes that the two pattern registers carry.
    localparam int PAT_BYTES   = 16;
    // One cell for each earlier byte of the window.
    localparam int CELL_COUNT  = PATTERN_MAX - 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int FILL_W      = $clog2(PATTERN_MAX);
    localparam int IDX_W       = FILL_W;

    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PLEN_W      = 5;
    localparam int COUNT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Control handed to each cell of the window chain.
    typedef struct packed {
        logic       shift;
        logic       active;
        logic [7:0] expected;
    } cell_ctrl_t;

    // Selects one pattern byte; bytes beyond the registers read as zero.
    function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = '0;
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            if (int'(idx) == i)
            begin
                b = pat[i*8 +: 8];
            end
        end
        return b;
    endfunction

endpackage

// ===== hdl/snc_in_if.sv =====
// Request channel carrying text bytes into the counter.
`timescale 1ns / 1ps

interface snc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== hdl/snc_out_if.sv =====
// Request channel carrying match results out of the counter.
`timescale 1ns / 1ps

interface snc_out_if;
    logic        valid;
    logic        ready;
    logic        match_here;
    logic [31:0] match_total;
    logic        text_done;

    modport source (output valid, output match_here, output match_total,
                    output text_done, input ready);
    modport sink   (input valid, input match_here, input match_total,
                    input text_done, output ready);
endinterface

// ===== hdl/snc_cell.sv =====
// One cell of the window chain: holds an earlier text byte and compares it.
`timescale 1ns / 1ps

module snc_cell
    import snc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out,
    output logic       match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbour's byte when the window advances.
    assign byte_next = ctrl.shift ? byte_in : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // A cell outside the current pattern length always agrees.
    assign match    = !ctrl.active || (byte_reg == ctrl.expected);
    assign byte_out = byte_reg;

endmodule

// ===== hdl/substring_occurrence_counter.sv =====
// Top level of the substring occurrence counter.
`timescale 1ns / 1ps

// Counts overlapping occurrences of a 1 to 16 byte pattern in a byte stream.
// text_in carries one text byte per request with an end_of_text mark;
// result_out returns exactly one request per byte: match_here, the running
// match_total (saturating) and text_done, which echoes end_of_text.
// The result of an accepted byte is registered and appears on result_out in the cycle after acceptance.
// Throughput is one byte per cycle: the window is a chain of byte cells that
// shifts and compares in parallel, and the result sits in an output register,
// so a new byte is taken whenever that register is empty or being drained.
// When the receiver stalls, the result is held and text_in.ready drops until
// it is taken. Occurrences never span a newline; a zero byte hides the rest
// of its line. After an end_of_text byte the count and line state clear.
// Pattern registers are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while the block is idle, as the block does not enforce it. Reset clears
// the window, the count and the output valid, and sets the pattern to zero with a length of one.
module substring_occurrence_counter
    import snc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    snc_in_if.sink               text_in,
    snc_out_if.source            result_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]       pat_low_reg,  pat_low_next;
    logic [CFG_W-1:0]       pat_high_reg, pat_high_next;
    logic [PLEN_W-1:0]      plen_reg,     plen_next;
    logic [FILL_W-1:0]      fill_reg,     fill_next;
    logic                   hidden_reg,   hidden_next;
    logic [COUNT_W-1:0]     count_reg,    count_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_match_reg, out_match_next;
    logic [COUNT_W-1:0]     out_total_reg, out_total_next;
    logic                   out_done_reg,  out_done_next;

    logic [8*PAT_BYTES-1:0] pattern;
    logic [LEN_W-1:0]       eff_len;
    logic                   accept;
    logic                   visible;
    logic                   fill_ok;
    logic                   last_ok;
    logic                   hit;
    logic                   shift;
    logic [COUNT_W-1:0]     count_hit;
    logic [CELL_COUNT-1:0]  cell_match;
    logic [7:0]             cell_byte [CELL_COUNT];

    // Configuration register writes.
    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        plen_next     = plen_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pat_low_next  = cfg_data;
                REG_PATTERN_HIGH:   pat_high_next = cfg_data;
                REG_PATTERN_LENGTH: plen_next     = cfg_data[PLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign pattern = {pat_high_reg, pat_low_reg};

    // Effective length: zero counts as one, and it is clipped to the window.
    always_comb
    begin
        if (plen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (int'(plen_reg) > PATTERN_MAX)
        begin
            eff_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            eff_len = LEN_W'(plen_reg);
        end
    end

    assign accept  = text_in.valid && text_in.ready;
    assign visible = !hidden_reg && (text_in.text_byte != 8'h00);
    assign shift   = accept && visible && (text_in.text_byte != NEWLINE_BYTE);

    // Chain of window cells; cell k holds the byte k+1 positions back.
    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        cell_ctrl_t       ctrl;
        logic [IDX_W-1:0] idx;

        assign idx           = IDX_W'(int'(eff_len) - 2 - k);
        assign ctrl.shift    = shift;
        assign ctrl.active   = (k + 1) < int'(eff_len);
        assign ctrl.expected = pat_byte(pattern, idx);

        if (k == 0)
        begin : g_head
            snc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .byte_in  (text_in.text_byte),
                .byte_out (cell_byte[k]),
                .match    (cell_match[k])
            );
        end
        else
        begin : g_body
            snc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .byte_in  (cell_byte[k-1]),
                .byte_out (cell_byte[k]),
                .match    (cell_match[k])
            );
        end
    end

    // Match decision for the current byte.
    assign fill_ok   = (LEN_W'(fill_reg) + LEN_W'(1)) >= eff_len;
    assign last_ok   = text_in.text_byte == pat_byte(pattern, IDX_W'(eff_len - LEN_W'(1)));
    assign hit       = visible && fill_ok && last_ok && (&cell_match);
    assign count_hit = (hit && (count_reg != COUNT_MAX)) ? count_reg + COUNT_W'(1) : count_reg;

    // Line state and count update for an accepted byte.
    always_comb
    begin
        fill_next   = fill_reg;
        hidden_next = hidden_reg;
        count_next  = count_reg;
        if (accept)
        begin
            count_next = count_hit;
            if (text_in.text_byte == NEWLINE_BYTE)
            begin
                fill_next   = '0;
                hidden_next = 1'b0;
            end
            else if (!hidden_reg)
            begin
                if (text_in.text_byte == 8'h00)
                begin
                    hidden_next = 1'b1;
                    fill_next   = '0;
                end
                else if (fill_reg != FILL_W'(CELL_COUNT))
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            if (text_in.end_of_text)
            begin
                count_next  = '0;
                fill_next   = '0;
                hidden_next = 1'b0;
            end
        end
    end

    // Output register; it refills in the same cycle that it drains.
    assign text_in.ready = !out_valid_reg || result_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_match_next = out_match_reg;
        out_total_next = out_total_reg;
        out_done_next  = out_done_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_match_next = hit;
            out_total_next = count_hit;
            out_done_next  = text_in.end_of_text;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            plen_reg      <= PLEN_W'(1);
            fill_reg      <= '0;
            hidden_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            plen_reg      <= plen_next;
            fill_reg      <= fill_next;
            hidden_reg    <= hidden_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_match_reg <= out_match_next;
        out_total_reg <= out_total_next;
        out_done_reg  <= out_done_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.match_here  = out_match_reg;
    assign result_out.match_total = out_total_reg;
    assign result_out.text_done   = out_done_reg;

    // A reported match always leaves a non-zero total.
    a_match_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_match_reg) |-> (out_total_reg != '0))
        else $error("match reported with a zero total");

    // The count restarts after the last byte of a text.
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_in.end_of_text) |=> (count_reg == '0))
        else $error("count not cleared after end of text");

    // A hidden line keeps an empty window.
    a_hidden_empty: assert property (@(posedge clk) disable iff (!rst_n)
        hidden_reg |-> (fill_reg == '0))
        else $error("window filled while the line is hidden");

    // An empty output register never blocks the input.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> text_in.ready)
        else $error("input stalled with an empty output register");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the substring occurrence counter.
`timescale 1ns / 1ps

module tb;
    import snc_pkg::*;

    // Configuration index that selects no register; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic       [7:0]         text_byte;
        logic                     end_of_text;
    } text_req_t;

    typedef struct packed {
        logic                     match_here;
        logic       [COUNT_W-1:0] match_total;
        logic                     text_done;
    } match_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    snc_in_if  text_in ();
    snc_out_if result_out ();

    substring_occurrence_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Pattern registers as the counter should currently hold them.
    logic [CFG_W-1:0]   cfg_pattern_low    = '0;
    logic [CFG_W-1:0]   cfg_pattern_high   = '0;
    logic [PLEN_W-1:0]  cfg_pattern_length = 5'd1;

    // Line state of the counter: earlier visible bytes, most recent first.
    logic [7:0]         seen_bytes [PATTERN_MAX-1] = '{default: 8'h00};
    int unsigned        seen_fill   = 0;
    bit                 seen_hidden = 1'b0;
    logic [COUNT_W-1:0] text_count  = '0;

    text_req_t          pending_text [$];
    match_result_t      awaited_counts [$];
    logic [7:0]         motif [$];
    int unsigned        issued_count   = 0;
    int unsigned        accepted_count = 0;
    int unsigned        mismatches     = 0;
    logic               byte_taken     = 1'b0;
    int unsigned        send_gap       = 0;
    int unsigned        hold_left      = 0;
    bit                 tx_calm        = 1'b0;
    bit                 rx_calm        = 1'b0;

    // Pattern length after the counter's clamping of out-of-range values.
    function automatic int unsigned active_length();
        if (cfg_pattern_length == 0)
        begin
            return 1;
        end
        if (cfg_pattern_length > PATTERN_MAX)
        begin
            return PATTERN_MAX;
        end
        return cfg_pattern_length;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned idx);
        logic [2*CFG_W-1:0] all_bytes;
        all_bytes = {cfg_pattern_high, cfg_pattern_low};
        return all_bytes[8*idx +: 8];
    endfunction

    // Works out the result for one text byte and advances the line state.
    function automatic match_result_t scan_byte(input logic [7:0] b, input logic eot);
        match_result_t res;
        int unsigned   len;
        int unsigned   k;
        logic          hit;
        len = active_length();
        hit = !seen_hidden && (b != 8'h00) && (seen_fill + 1 >= len) && (b == pattern_at(len - 1));
        for (k = 0; k + 1 < len; k++)
        begin
            if (seen_bytes[k] != pattern_at(len - 2 - k))
            begin
                hit = 1'b0;
            end
        end
        if (hit && text_count != COUNT_MAX)
        begin
            text_count++;
        end
        res.match_here  = hit;
        res.match_total = text_count;
        res.text_done   = eot;

        // A newline restarts the line; a zero byte hides the rest of it.
        if (b == NEWLINE_BYTE)
        begin
            seen_fill   = 0;
            seen_hidden = 1'b0;
        end
        else if (!seen_hidden)
        begin
            if (b == 8'h00)
            begin
                seen_hidden = 1'b1;
                seen_fill   = 0;
            end
            else
            begin
                for (k = PATTERN_MAX - 2; k > 0; k--)
                begin
                    seen_bytes[k] = seen_bytes[k - 1];
                end
                seen_bytes[0] = b;
                if (seen_fill < PATTERN_MAX - 1)
                begin
                    seen_fill++;
                end
            end
        end

        if (eot)
        begin
            text_count  = '0;
            seen_fill   = 0;
            seen_hidden = 1'b0;
        end
        return res;
    endfunction

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int unsigned idle_span(input bit calm);
        int unsigned r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 94)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Random pattern drawn from a small set of letters, which favours overlaps.
    function automatic logic [2*CFG_W-1:0] pick_pattern(input int unsigned n_letters);
        logic [7:0]         letters [16];
        logic [2*CFG_W-1:0] bits;
        int unsigned        i;
        for (i = 0; i < 16; i++)
        begin
            letters[i] = 8'($urandom_range(1, 255));
            if (letters[i] == NEWLINE_BYTE)
            begin
                letters[i] = 8'h0B;
            end
        end
        for (i = 0; i < 16; i++)
        begin
            bits[8*i +: 8] = letters[$urandom_range(0, n_letters - 1)];
        end
        return bits;
    endfunction

    // Text is mostly whole or broken copies of the pattern, with noise mixed in.
    function automatic logic [7:0] next_text_byte();
        int unsigned pick;
        int unsigned span;
        int unsigned len;
        int unsigned pos;
        len  = active_length();
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            return NEWLINE_BYTE;
        end
        if (pick < 8)
        begin
            return 8'h00;
        end
        if (pick < 18)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (pick < 32)
        begin
            return pattern_at($urandom_range(0, len - 1));
        end
        if (motif.size() == 0)
        begin
            span = ($urandom_range(0, 9) < 6) ? len : $urandom_range(1, len);
            for (pos = 0; pos < span; pos++)
            begin
                motif.push_back(pattern_at(pos));
            end
            if ($urandom_range(0, 9) >= 8)
            begin
                motif[$urandom_range(0, span - 1)] = 8'($urandom_range(0, 255));
            end
        end
        return motif.pop_front();
    endfunction

    task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        pending_text.push_back('{text_byte: b, end_of_text: eot});
        issued_count++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], 1'b0);
        end
    endtask

    // Waits until every request has been taken and every result has come back.
    task automatic wait_idle();
        while (accepted_count != issued_count || awaited_counts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_PATTERN_LOW:    cfg_pattern_low    = data;
            REG_PATTERN_HIGH:   cfg_pattern_high   = data;
            REG_PATTERN_LENGTH: cfg_pattern_length = data[PLEN_W-1:0];
            default:            ;
        endcase
    endtask

    // Loads all three pattern registers; the length word carries random upper bits.
    task automatic load_pattern(input logic [PLEN_W-1:0] length_code,
                                input logic [2*CFG_W-1:0] bits);
        logic [CFG_W-1:0] length_word;
        length_word = {$urandom, $urandom};
        length_word[PLEN_W-1:0] = length_code;
        write_reg(REG_PATTERN_LOW, bits[CFG_W-1:0]);
        write_reg(REG_PATTERN_HIGH, bits[2*CFG_W-1:CFG_W]);
        write_reg(REG_PATTERN_LENGTH, length_word);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [PLEN_W-1:0] length_code,
                             input logic [2*CFG_W-1:0] bits, input int unsigned items);
        int unsigned n;
        wait_idle();
        load_pattern(length_code, bits);
        motif.delete();
        for (n = 0; n < items; n++)
        begin
            send_byte(next_text_byte(), (n == items - 1) || ($urandom_range(0, 29) == 0));
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Request driver: presents queued text bytes with random gaps.
    always @(negedge clk)
    begin
        text_req_t req;
        if (!rst_n)
        begin
            text_in.valid <= 1'b0;
        end
        else if (!text_in.valid || byte_taken)
        begin
            if (send_gap > 0)
            begin
                text_in.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_text.size() != 0)
            begin
                req = pending_text.pop_front();
                text_in.valid       <= 1'b1;
                text_in.text_byte   <= req.text_byte;
                text_in.end_of_text <= req.end_of_text;
                send_gap = idle_span(tx_calm);
                if ($urandom_range(0, 63) == 0)
                begin
                    tx_calm = !tx_calm;
                end
            end
            else
            begin
                text_in.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at random.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            result_out.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            result_out.ready <= 1'b1;
            hold_left = idle_span(rx_calm);
            if ($urandom_range(0, 199) == 0)
            begin
                rx_calm = !rx_calm;
            end
        end
    end

    // Monitor: checks each returned result and predicts each accepted request.
    always @(posedge clk)
    begin
        match_result_t want;
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
        end
        else
        begin
            byte_taken <= text_in.valid && text_in.ready;
            if (result_out.valid && result_out.ready)
            begin
                if (awaited_counts.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual total %0h",
                             $time, result_out.match_total);
                    mismatches++;
                end
                else
                begin
                    want = awaited_counts.pop_front();
                    check_field("match_here", want.match_here, result_out.match_here);
                    check_field("match_total", want.match_total, result_out.match_total);
                    check_field("text_done", want.text_done, result_out.text_done);
                end
            end
            if (text_in.valid && text_in.ready)
            begin
                awaited_counts.push_back(scan_byte(text_in.text_byte, text_in.end_of_text));
                accepted_count++;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int unsigned        len;
        logic [2*CFG_W-1:0] bits;

        text_in.valid       = 1'b0;
        text_in.text_byte   = 8'h00;
        text_in.end_of_text = 1'b0;
        result_out.ready    = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_PATTERN_LOW;
        cfg_data            = '0;
        rst_n               = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset pattern is a single zero byte, which can never match.
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Overlapping hits, a hidden line and a hit that closes the text.
        wait_idle();
        load_pattern(5'd3, 128'h616261);
        write_reg(REG_SPARE, '1);
        @(negedge clk);
        cfg_we <= 1'b0;
        send_text("ababa\nba");
        send_byte(8'h00, 1'b0);
        send_text("aba\nab");
        send_byte(8'h61, 1'b1);

        // Pattern whose last byte is a newline.
        wait_idle();
        load_pattern(5'd2, {120'h0, 8'h61} | (128'(NEWLINE_BYTE) << 8));
        send_text("a\na");
        send_byte(NEWLINE_BYTE, 1'b1);

        // Random phases across lengths, clamped lengths and awkward patterns.
        run_phase(5'd1, pick_pattern(3), 90);
        run_phase(5'd0, pick_pattern(2), 90);
        run_phase(5'd2, pick_pattern(2), 90);
        run_phase(5'($urandom_range(3, 8)), pick_pattern(2), 90);
        run_phase(5'd16, '1, 90);
        run_phase(5'd31, pick_pattern(2), 90);
        run_phase(5'($urandom_range(9, 15)), pick_pattern(3), 90);
        len  = $urandom_range(2, 16);
        bits = pick_pattern(3);
        bits[8*$urandom_range(0, len - 1) +: 8] = 8'h00;
        run_phase(5'(len), bits, 90);
        len  = $urandom_range(2, 8);
        bits = pick_pattern(2);
        bits[8*(len - 1) +: 8] = NEWLINE_BYTE;
        run_phase(5'(len), bits, 90);
        run_phase(5'd16, pick_pattern(16), 90);

        wait_idle();
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/snc_pkg.sv
hdl/snc_in_if.sv
hdl/snc_out_if.sv
hdl/snc_cell.sv
hdl/substring_occurrence_counter.sv
verif/tb.sv
